// ===== rtl/core/mlt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MIDI learn mapping table.
// No dependencies; imported by mlt_table and midi_learn_mapping_table.
package mlt_pkg;

  // width of a row index on the ports
  localparam int ROW_W = 6;

  // MIDI status byte fields
  localparam logic [7:0] NIB_LOW     = 8'h0F;
  localparam logic [7:0] NIB_HIGH    = 8'hF0;
  localparam logic [7:0] CMD_NOTE_ON = 8'h90;
  localparam logic [7:0] CMD_CC      = 8'hB0;

  // knob targets
  localparam logic [3:0] TARGET_NONE = 4'd0;
  localparam logic [3:0] TARGET_HUE  = 4'd1;

  // result kinds
  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_KNOB   = 2'd1;
  localparam logic [1:0] KIND_LEARN  = 2'd2;

  // request modes
  typedef enum logic [1:0] {
    MODE_MSG    = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // row type
  typedef enum logic [1:0] {
    RT_NONE   = 2'd0,
    RT_BUTTON = 2'd1,
    RT_KNOB   = 2'd2
  } rtype_t;

  // one stored row; a row is active when its valid flop in mlt_table is set
  typedef struct packed {
    logic [4:0] channel;
    rtype_t     rtype;
    logic [7:0] note;
    logic [7:0] ctrl;
    logic [3:0] target;
  } row_t;

  // table access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } tbl_ctl_t;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEARN_WR,
    ST_SCAN
  } state_t;

endpackage

// ===== rtl/core/mlt_table.sv =====
`timescale 1ns / 1ps
// Row storage: synchronous memory with registered read, plus
// per-row valid flops that reset clears. Depends on mlt_pkg.
module mlt_table
  import mlt_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  tbl_ctl_t         ctl,
  input  logic [ROW_W-1:0] rd_addr,
  input  logic [ROW_W-1:0] wr_addr,
  input  row_t             wr_row,
  output row_t             rd_row,
  output logic             rd_hit
);

  localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;

  row_t            mem [ROWS];
  logic [ROWS-1:0] vld;

  // memory write and registered read; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr[IW-1:0]] <= wr_row;
    end
    if (ctl.rd_en) begin
      rd_row <= mem[rd_addr[IW-1:0]];
    end
  end

  // valid bits: set on write, cleared by reset or a row clear
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld[wr_addr[IW-1:0]] <= 1'b1;
      end else if (ctl.clr_en) begin
        vld[wr_addr[IW-1:0]] <= 1'b0;
      end
      if (ctl.rd_en) begin
        rd_hit <= vld[rd_addr[IW-1:0]];
      end
    end
  end

endmodule

// ===== rtl/core/midi_learn_mapping_table.sv =====
`timescale 1ns / 1ps
// MIDI learn mapping table: learn, clear and row-by-row matching of messages.
// Depends on mlt_pkg and mlt_table.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  input   | in_valid in_stall mode status data1 data2 row_index | in
//  output  | out_valid out_stall event_kind matched_row value  | out
//          | knob_target last                                  |
//
// Arm, cancel and clear complete in idle and raise no stall. A learned message
// reads the armed row, then does the write-back and the result once the output
// is free. Any other message scans one row a cycle while no match is held back
// by the output stall, and in_stall stays high until the scan has finished.
// One found match waits in a hold register so the last one can be marked.
// Reset clears the valid flops at once; there is no clearing pass.
module midi_learn_mapping_table
  import mlt_pkg::*;
#(
  parameter int ROWS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  logic [7:0]       status,
  input  logic [7:0]       data1,
  input  logic [7:0]       data2,
  input  logic [ROW_W-1:0] row_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       event_kind,
  output logic [ROW_W-1:0] matched_row,
  output logic [7:0]       value,
  output logic [3:0]       knob_target,
  output logic             last
);

  localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(ROWS + 1);

  state_t          state, state_next;
  logic            learning;
  logic [IW-1:0]   learn_row;
  logic            msg_note_on, msg_cc;
  logic [4:0]      msg_chan;
  logic [7:0]      msg_d1, msg_d2;
  logic [CW-1:0]   issue_cnt;
  logic            eval_v;
  logic [IW-1:0]   eval_idx;
  logic            hold_v;
  logic [1:0]      hold_kind;
  logic [IW-1:0]   hold_row;
  logic [3:0]      hold_target;
  logic            ov, o_last;
  logic [1:0]      o_kind;
  logic [IW-1:0]   o_row;
  logic [7:0]      o_value;
  logic [3:0]      o_target;

  tbl_ctl_t         ctl;
  logic [ROW_W-1:0] rd_addr, wr_addr;
  row_t             rd_row, old_row, new_row;
  logic             rd_hit;

  logic in_acc, out_free, in_range, chan_ok, btn_hit, knb_hit, ev_match;
  logic scan_hold, scan_issue, scan_done, load_learn, load_mid, load_fin;
  mode_t in_mode;

  assign in_mode  = mode_t'(mode);
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov || !out_stall;
  assign in_range = ({1'b0, row_index} < (ROW_W + 1)'(ROWS));

  // row storage
  mlt_table #(.ROWS(ROWS)) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_row  (new_row),
    .rd_row  (rd_row),
    .rd_hit  (rd_hit)
  );

  // match test on the row just read
  always_comb begin
    chan_ok  = (rd_row.channel == 5'd0) || (rd_row.channel == msg_chan);
    btn_hit  = rd_hit && chan_ok && (rd_row.rtype == RT_BUTTON) && msg_note_on &&
               (msg_d1 == rd_row.note) && (msg_d2 != 8'd0);
    knb_hit  = rd_hit && chan_ok && (rd_row.rtype == RT_KNOB) && msg_cc &&
               (msg_d1 == rd_row.ctrl);
    ev_match = (state == ST_SCAN) && eval_v && (btn_hit || knb_hit);
  end

  // learned row from the old contents
  always_comb begin
    old_row         = rd_hit ? rd_row : '0;
    new_row         = old_row;
    new_row.channel = msg_chan;
    if (msg_note_on) begin
      new_row.rtype = RT_BUTTON;
      new_row.note  = msg_d1;
      new_row.ctrl  = 8'd0;
    end else if (msg_cc) begin
      new_row.rtype = RT_KNOB;
      new_row.ctrl  = msg_d1;
      new_row.note  = 8'd0;
      if (old_row.target == TARGET_NONE) begin
        new_row.target = TARGET_HUE;
      end
    end
  end

  // sequencer: next state and table strobes
  always_comb begin
    state_next = state;
    ctl        = '0;
    rd_addr    = ROW_W'(issue_cnt[IW-1:0]);
    wr_addr    = ROW_W'(learn_row);
    scan_hold  = ev_match && hold_v && !out_free;
    scan_issue = 1'b0;
    scan_done  = 1'b0;
    load_learn = 1'b0;
    load_mid   = 1'b0;
    load_fin   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_MSG: begin
              if (learning) begin
                ctl.rd_en  = 1'b1;
                rd_addr    = ROW_W'(learn_row);
                state_next = ST_LEARN_WR;
              end else begin
                state_next = ST_SCAN;
              end
            end
            MODE_CLEAR: begin
              ctl.clr_en = in_range;
              wr_addr    = row_index;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LEARN_WR: begin
        if (out_free) begin
          ctl.wr_en  = 1'b1;
          load_learn = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        scan_issue = (issue_cnt < CW'(ROWS)) && !scan_hold;
        ctl.rd_en  = scan_issue;
        load_mid   = ev_match && hold_v && out_free;
        scan_done  = (issue_cnt == CW'(ROWS)) && !eval_v;
        if (scan_done) begin
          if (!hold_v) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            load_fin   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register and control flops
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      learning  <= 1'b0;
      learn_row <= '0;
      issue_cnt <= '0;
      eval_v    <= 1'b0;
      hold_v    <= 1'b0;
      ov        <= 1'b0;
    end else begin
      state <= state_next;

      // learn arming
      if (in_acc && in_mode == MODE_ARM && in_range) begin
        learning  <= 1'b1;
        learn_row <= row_index[IW-1:0];
      end else if ((in_acc && in_mode == MODE_CANCEL) || load_learn) begin
        learning  <= 1'b0;
        learn_row <= '0;
      end

      // scan read pointer and eval stage
      if (in_acc) begin
        issue_cnt <= '0;
      end else if (scan_issue) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      if (!scan_hold) begin
        eval_v <= scan_issue;
      end

      // hold register valid
      if (ev_match && !scan_hold) begin
        hold_v <= 1'b1;
      end else if (load_fin) begin
        hold_v <= 1'b0;
      end

      // output beat valid
      if (load_learn || load_mid || load_fin) begin
        ov <= 1'b1;
      end else if (!out_stall) begin
        ov <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      msg_note_on <= ((status & NIB_HIGH) == CMD_NOTE_ON);
      msg_cc      <= ((status & NIB_HIGH) == CMD_CC);
      msg_chan    <= 5'((status & NIB_LOW)) + 5'd1;
      msg_d1      <= data1;
      msg_d2      <= data2;
    end
    if (!scan_hold) begin
      eval_idx <= issue_cnt[IW-1:0];
    end
    if (ev_match && !scan_hold) begin
      hold_kind   <= btn_hit ? KIND_BUTTON : KIND_KNOB;
      hold_row    <= eval_idx;
      hold_target <= btn_hit ? TARGET_NONE : rd_row.target;
    end
    if (load_learn) begin
      o_kind   <= KIND_LEARN;
      o_row    <= learn_row;
      o_value  <= msg_d2;
      o_target <= new_row.target;
      o_last   <= 1'b1;
    end else if (load_mid || load_fin) begin
      o_kind   <= hold_kind;
      o_row    <= hold_row;
      o_value  <= msg_d2;
      o_target <= hold_target;
      o_last   <= load_fin;
    end
  end

  assign out_valid   = ov;
  assign event_kind  = o_kind;
  assign matched_row = ROW_W'(o_row);
  assign value       = o_value;
  assign knob_target = o_target;
  assign last        = o_last;

  // no match left behind once the scan has finished
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!hold_v && !eval_v))
    else $error("match pending outside scan");

  // a learn beat is always the only and last beat of its message
  a_learn_last: assert property (@(posedge clk) disable iff (rst)
    (ov && o_kind == KIND_LEARN) |-> o_last)
    else $error("learn beat not marked last");

  // writing back the learned row ends learning
  a_learn_ends: assert property (@(posedge clk) disable iff (rst)
    load_learn |=> !learning)
    else $error("learning still armed after write-back");

  // the read pointer never runs past the table
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_cnt <= CW'(ROWS)))
    else $error("scan pointer out of range");

endmodule
